// ----- sv/vsw_pkg.sv -----
// Package for the swirl point warp: widths, fixed-point constants, CORDIC angle table,
// register codes and the item and stage structs.
// No dependencies; every other file imports it.
package vsw_pkg;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = COORD_BITS + FRAC_BITS + 1;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ANG_W      = FRAC_BITS + 4;
    localparam int Q48_W      = 63;
    localparam int WRAP_STEPS = 13;
    localparam int GAIN_W     = 16;
    localparam int TIME_W     = 32;
    localparam int SCALE_W    = GAIN_W + 5;
    localparam int NUM_W      = SCALE_W + ANG_W + FRAC_BITS - 12;
    localparam int QUO_W      = NUM_W - (FRAC_BITS + 2);
    localparam int DIV_W      = ROOT_W + QUO_W;
    localparam int ROT_W      = DIFF_W + ANG_W;
    localparam int SUM_W      = ROT_W + 3;
    localparam int TRUNC_W    = SUM_W - FRAC_BITS;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIRL_GAIN = 4'd3;
    localparam logic [GAIN_W-1:0]    GAIN_RESET     = 16'd256;

    localparam logic [Q48_W-1:0] PI_Q48     = 63'h3243F6A8885A3;
    localparam logic [Q48_W-1:0] TWO_PI_Q48 = 63'h6487ED5110B46;
    localparam logic [Q48_W-1:0] PI_QF_U    = PI_Q48 >> (48 - FRAC_BITS);
    localparam logic [Q48_W-1:0] HALF_QF_U  = PI_Q48 >> (49 - FRAC_BITS);
    localparam logic signed [ANG_W-1:0] PI_QF   = PI_QF_U[ANG_W-1:0];
    localparam logic signed [ANG_W-1:0] HALF_QF = HALF_QF_U[ANG_W-1:0];

    localparam logic [31:0] K_Q30  = 32'h26DD3B6A;
    localparam logic [31:0] K_QF_U = (K_Q30 + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic signed [ANG_W-1:0] CORDIC_X0 = K_QF_U[ANG_W-1:0];

    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    function automatic logic signed [ANG_W-1:0] atan_qf(input int idx);
        logic [31:0] v;
        v = (ATAN_Q30[idx] + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return v[ANG_W-1:0];
    endfunction

    typedef struct packed {
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         near_centre;
        logic                         clipped;
    } t_out_item;

    // everything an item carries down the pipe; later fields fill in as it goes
    typedef struct packed {
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [GAIN_W-1:0]     gain;
        logic [TIME_W-1:0]            ftime;
        logic signed [DIFF_W-1:0]     dx;
        logic signed [DIFF_W-1:0]     dy;
        logic                         near;
        logic [SQ_W-1:0]              d2;
        logic [ROOT_W-1:0]            dq;
        logic signed [ANG_W-1:0]      ts;
        logic [NUM_W-1:0]             num;
        logic                         neg;
        logic [QUO_W-1:0]             amag;
        logic signed [ANG_W-1:0]      ca;
        logic signed [ANG_W-1:0]      sa;
    } t_side;

endpackage

// ----- sv/vsw_sqrt.sv -----
// Pipelined integer square root: one result bit per stage, d = floor(sqrt(d2 * 2^2F)).
// Depends on vsw_pkg.
module vsw_sqrt import vsw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_side i_side,
    output logic  o_valid,
    output t_side o_side
);

    logic              r_valid [ROOT_W];
    t_side             r_side  [ROOT_W];
    logic [REM_W-1:0]  r_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int POS = COORD_BITS - s;
        logic              v_in;
        t_side             side_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [1:0]        pair;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_valid[s-1];
            assign side_in = r_side[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // radicand bits below the binary point are zero
        if (POS >= 0) begin : g_pair
            assign pair = side_in.d2[2*POS +: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_in[REM_W-3:0], pair};
        assign trial  = REM_W'({root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_adv) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[s] <= side_in;
                if (rem_sh >= trial) begin
                    r_rem[s]  <= rem_sh - trial;
                    r_root[s] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= rem_sh;
                    r_root[s] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];

    always_comb begin
        o_side    = r_side[ROOT_W-1];
        o_side.dq = r_root[ROOT_W-1];
    end

endmodule

// ----- sv/vsw_wrap.sv -----
// Angle reduction: a Q48 magnitude with sign is taken modulo 2*pi by compare and subtract,
// one quotient bit per stage, then folded to [-pi, pi] and cut to QF. Depends on vsw_pkg.
module vsw_wrap import vsw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_side                   i_side,
    input  logic [Q48_W-1:0]        i_mag,
    input  logic                    i_neg,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic signed [ANG_W-1:0] o_ang
);

    logic             r_valid [WRAP_STEPS];
    t_side            r_side  [WRAP_STEPS];
    logic [Q48_W-1:0] r_r     [WRAP_STEPS];
    logic             r_neg   [WRAP_STEPS];

    for (genvar s = 0; s < WRAP_STEPS; s++) begin : g_stage
        localparam logic [Q48_W-1:0] CAND = TWO_PI_Q48 << (WRAP_STEPS - 1 - s);
        logic             v_in;
        t_side            side_in;
        logic [Q48_W-1:0] r_in;
        logic             neg_in;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign r_in    = i_mag;
            assign neg_in  = i_neg;
        end else begin : g_next
            assign v_in    = r_valid[s-1];
            assign side_in = r_side[s-1];
            assign r_in    = r_r[s-1];
            assign neg_in  = r_neg[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_adv) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[s] <= side_in;
                r_neg[s]  <= neg_in;
                r_r[s]    <= (r_in >= CAND) ? (r_in - CAND) : r_in;
            end
        end
    end

    logic                    r_fvalid;
    t_side                   r_fside;
    logic signed [ANG_W-1:0] r_ang;
    logic [Q48_W-1:0]        n_fold;
    logic [Q48_W-1:0]        n_shift;
    logic                    n_neg;

    // fold the upper half turn back onto the negative side
    always_comb begin
        if (r_r[WRAP_STEPS-1] > PI_Q48) begin
            n_fold = TWO_PI_Q48 - r_r[WRAP_STEPS-1];
            n_neg  = !r_neg[WRAP_STEPS-1];
        end else begin
            n_fold = r_r[WRAP_STEPS-1];
            n_neg  = r_neg[WRAP_STEPS-1];
        end
        n_shift = n_fold >> (48 - FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else if (i_adv) begin
            r_fvalid <= r_valid[WRAP_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fside <= r_side[WRAP_STEPS-1];
            r_ang   <= n_neg ? -$signed(n_shift[ANG_W-1:0]) : $signed(n_shift[ANG_W-1:0]);
        end
    end

    assign o_valid = r_fvalid;
    assign o_side  = r_fside;
    assign o_ang   = r_ang;

endmodule

// ----- sv/vsw_cordic.sv -----
// Rotation-mode CORDIC, one micro-rotation per stage, giving cos and sin of a QF angle
// in [-pi, pi]. A quadrant stage in front moves the angle into [-pi/2, pi/2]. Depends on vsw_pkg.
module vsw_cordic import vsw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_side                   i_side,
    input  logic signed [ANG_W-1:0] i_theta,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic signed [ANG_W-1:0] o_cos,
    output logic signed [ANG_W-1:0] o_sin
);

    localparam int N = CORDIC_STEPS + 1;

    logic                    r_valid [N];
    t_side                   r_side  [N];
    logic signed [ANG_W-1:0] r_x     [N];
    logic signed [ANG_W-1:0] r_y     [N];
    logic signed [ANG_W-1:0] r_th    [N];
    logic                    r_flip  [N];

    logic signed [ANG_W-1:0] n_th0;
    logic                    n_flip0;

    always_comb begin
        priority if (i_theta > HALF_QF) begin
            n_th0   = i_theta - PI_QF;
            n_flip0 = 1'b1;
        end else if (i_theta < -HALF_QF) begin
            n_th0   = i_theta + PI_QF;
            n_flip0 = 1'b1;
        end else begin
            n_th0   = i_theta;
            n_flip0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            r_x[0]    <= CORDIC_X0;
            r_y[0]    <= '0;
            r_th[0]   <= n_th0;
            r_flip[0] <= n_flip0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [ANG_W-1:0] ATAN = atan_qf(i);
        logic signed [ANG_W-1:0] xs;
        logic signed [ANG_W-1:0] ys;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_adv) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[i+1] <= r_side[i];
                r_flip[i+1] <= r_flip[i];
                if (r_th[i] >= 0) begin
                    r_x[i+1]  <= r_x[i] - ys;
                    r_y[i+1]  <= r_y[i] + xs;
                    r_th[i+1] <= r_th[i] - ATAN;
                end else begin
                    r_x[i+1]  <= r_x[i] + ys;
                    r_y[i+1]  <= r_y[i] - xs;
                    r_th[i+1] <= r_th[i] + ATAN;
                end
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_side  = r_side[N-1];
    assign o_cos   = r_flip[N-1] ? -r_x[N-1] : r_x[N-1];
    assign o_sin   = r_flip[N-1] ? -r_y[N-1] : r_y[N-1];

endmodule

// ----- sv/vsw_div.sv -----
// Pipelined restoring divider: angle magnitude = num / d, one quotient bit per stage.
// Depends on vsw_pkg.
module vsw_div import vsw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_side i_side,
    output logic  o_valid,
    output t_side o_side
);

    logic             r_valid [QUO_W];
    t_side            r_side  [QUO_W];
    logic [NUM_W-1:0] r_rem   [QUO_W];
    logic [QUO_W-1:0] r_q     [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic             v_in;
        t_side            side_in;
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] q_in;
        logic [DIV_W-1:0] rem_ext;
        logic [DIV_W-1:0] cand;
        logic [DIV_W-1:0] diff;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign rem_in  = i_side.num;
            assign q_in    = '0;
        end else begin : g_next
            assign v_in    = r_valid[s-1];
            assign side_in = r_side[s-1];
            assign rem_in  = r_rem[s-1];
            assign q_in    = r_q[s-1];
        end

        assign rem_ext = DIV_W'(rem_in);
        assign cand    = DIV_W'(side_in.dq) << B;
        assign diff    = rem_ext - cand;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_adv) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[s] <= side_in;
                if (rem_ext >= cand) begin
                    r_rem[s] <= diff[NUM_W-1:0];
                    r_q[s]   <= {q_in[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[s] <= rem_in;
                    r_q[s]   <= {q_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];

    always_comb begin
        o_side      = r_side[QUO_W-1];
        o_side.amag = r_q[QUO_W-1];
    end

endmodule

// ----- sv/vortex_swirl_point_warp_top.sv -----
// Top level of the swirl point warp: configuration registers, offset and distance stages,
// the square root, angle and rotation pipeline, and the output register.
// Depends on vsw_pkg, vsw_sqrt, vsw_wrap, vsw_cordic and vsw_div.
//
//  channel  valid        ready        payload                   direction
//  in       i_in_valid   o_in_ready   i_in_data  (t_in_item)    point in
//  out      o_out_valid  i_out_ready  o_out_data (t_out_item)   warped point out
//  cfg      i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data   register write in
//
// One item enters per clock while the pipe is not stalled; the path runs through the 33-stage
// square root, the 27-stage divider, two 14-stage angle reductions, two 17-stage CORDIC units and
// seven single stages (offsets, square, numerator, products, sum, saturation, output) in series.
// Reset is synchronous and clears the valid bits and the configuration registers; no clearing pass.
// All stages advance together; a result waiting at the output stalls the pipe only once the
// last stage also holds an item, so bubbles still close up behind a stalled output.
// Configuration writes are always taken.
module vortex_swirl_point_warp_top import vsw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [TRUNC_W-1:0] C_MAX = TRUNC_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [TRUNC_W-1:0] C_MIN = TRUNC_W'(-(64'sd1 <<< (COORD_BITS - 1)));

    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    logic [TIME_W-1:0]            r_frame_time;
    logic signed [GAIN_W-1:0]     r_swirl_gain;

    logic adv;
    logic last_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_frame_time <= '0;
            r_swirl_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:   r_center_x   <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data[COORD_BITS-1:0];
                CFG_FRAME_TIME: r_frame_time <= i_cfg_data[TIME_W-1:0];
                CFG_SWIRL_GAIN: r_swirl_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // ---- stage 0: offsets from the centre
    logic  r0_valid;
    t_side r0_side;
    t_side n0_side;

    always_comb begin
        n0_side       = '0;
        n0_side.in_x  = i_in_data.in_x;
        n0_side.in_y  = i_in_data.in_y;
        n0_side.cx    = r_center_x;
        n0_side.cy    = r_center_y;
        n0_side.gain  = r_swirl_gain;
        n0_side.ftime = r_frame_time;
        n0_side.dx    = DIFF_W'(i_in_data.in_x) - DIFF_W'(r_center_x);
        n0_side.dy    = DIFF_W'(i_in_data.in_y) - DIFF_W'(r_center_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (adv) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_side <= n0_side;
        end
    end

    // ---- stage 1: squared distance and near test
    logic              r1_valid;
    t_side             r1_side;
    logic [DIFF_W-1:0] mag_x;
    logic [DIFF_W-1:0] mag_y;
    logic [SQ_W-1:0]   n1_d2;
    t_side             n1_side;

    assign mag_x = r0_side.dx[DIFF_W-1] ? DIFF_W'(-r0_side.dx) : DIFF_W'(r0_side.dx);
    assign mag_y = r0_side.dy[DIFF_W-1] ? DIFF_W'(-r0_side.dy) : DIFF_W'(r0_side.dy);
    assign n1_d2 = SQ_W'(mag_x) * SQ_W'(mag_x) + SQ_W'(mag_y) * SQ_W'(mag_y);

    always_comb begin
        n1_side      = r0_side;
        n1_side.d2   = n1_d2;
        n1_side.near = (n1_d2 < SQ_W'(25));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side <= n1_side;
        end
    end

    // ---- distance, then sin of half the frame time
    logic  sq_valid;
    t_side sq_side;

    vsw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r1_valid),
        .i_side  (r1_side),
        .o_valid (sq_valid),
        .o_side  (sq_side)
    );

    logic                    tw_valid;
    t_side                   tw_side;
    logic signed [ANG_W-1:0] tw_ang;

    vsw_wrap u_time_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_mag   ({sq_side.ftime, 31'b0}),
        .i_neg   (1'b0),
        .o_valid (tw_valid),
        .o_side  (tw_side),
        .o_ang   (tw_ang)
    );

    logic                    tc_valid;
    t_side                   tc_side;
    logic signed [ANG_W-1:0] tc_sin;

    vsw_cordic u_time_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (tw_valid),
        .i_side  (tw_side),
        .i_theta (tw_ang),
        .o_valid (tc_valid),
        .o_side  (tc_side),
        .o_cos   (),
        .o_sin   (tc_sin)
    );

    // ---- stage 2: numerator 20 * |gain| * |sin|, scaled so that dividing by the QF distance gives QF
    logic               r2_valid;
    t_side              r2_side;
    logic [GAIN_W:0]    gain_mag;
    logic [ANG_W-1:0]   sin_mag;
    logic [SCALE_W-1:0] gain_scaled;
    logic [NUM_W-1:0]   n2_num;
    t_side              n2_side;

    // the 16-bit negation of the most negative gain reads correctly as unsigned
    assign gain_mag    = tc_side.gain[GAIN_W-1] ? {1'b0, GAIN_W'(-tc_side.gain)}
                                                : {1'b0, tc_side.gain};
    assign sin_mag     = tc_sin[ANG_W-1] ? ANG_W'(-tc_sin) : ANG_W'(tc_sin);
    assign gain_scaled = (SCALE_W'(gain_mag) << 4) + (SCALE_W'(gain_mag) << 2);
    assign n2_num      = (NUM_W'(gain_scaled) * NUM_W'(sin_mag)) << (FRAC_BITS - 8);

    always_comb begin
        n2_side     = tc_side;
        n2_side.ts  = tc_sin;
        n2_side.num = n2_num;
        n2_side.neg = tc_side.gain[GAIN_W-1] ^ tc_sin[ANG_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= tc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_side <= n2_side;
        end
    end

    // ---- swirl angle, then its cos and sin
    logic  dv_valid;
    t_side dv_side;

    vsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r2_valid),
        .i_side  (r2_side),
        .o_valid (dv_valid),
        .o_side  (dv_side)
    );

    logic                    aw_valid;
    t_side                   aw_side;
    logic signed [ANG_W-1:0] aw_ang;

    vsw_wrap u_ang_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_mag   (Q48_W'(dv_side.amag) << (48 - FRAC_BITS)),
        .i_neg   (dv_side.neg),
        .o_valid (aw_valid),
        .o_side  (aw_side),
        .o_ang   (aw_ang)
    );

    logic                    ac_valid;
    t_side                   ac_side;
    logic signed [ANG_W-1:0] ac_cos;
    logic signed [ANG_W-1:0] ac_sin;

    vsw_cordic u_ang_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (aw_valid),
        .i_side  (aw_side),
        .i_theta (aw_ang),
        .o_valid (ac_valid),
        .o_side  (ac_side),
        .o_cos   (ac_cos),
        .o_sin   (ac_sin)
    );

    // ---- stage 3: rotation products
    logic                    r3_valid;
    t_side                   r3_side;
    logic signed [ROT_W-1:0] r3_xc;
    logic signed [ROT_W-1:0] r3_ys;
    logic signed [ROT_W-1:0] r3_xs;
    logic signed [ROT_W-1:0] r3_yc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= ac_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_side <= ac_side;
            r3_xc   <= ROT_W'(ac_side.dx) * ROT_W'(ac_cos);
            r3_ys   <= ROT_W'(ac_side.dy) * ROT_W'(ac_sin);
            r3_xs   <= ROT_W'(ac_side.dx) * ROT_W'(ac_sin);
            r3_yc   <= ROT_W'(ac_side.dy) * ROT_W'(ac_cos);
        end
    end

    // ---- stage 4: centre plus rotated offset, in QF
    logic                    r4_valid;
    t_side                   r4_side;
    logic signed [SUM_W-1:0] r4_tx;
    logic signed [SUM_W-1:0] r4_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_side <= r3_side;
            r4_tx   <= (SUM_W'(r3_side.cx) <<< FRAC_BITS) + SUM_W'(r3_xc) - SUM_W'(r3_ys);
            r4_ty   <= (SUM_W'(r3_side.cy) <<< FRAC_BITS) + SUM_W'(r3_xs) + SUM_W'(r3_yc);
        end
    end

    // ---- stage 5: truncate toward zero, saturate, pick pass-through for near points
    logic                      r5_valid;
    t_out_item                 r5_item;
    logic signed [TRUNC_W-1:0] vx;
    logic signed [TRUNC_W-1:0] vy;
    logic signed [COORD_BITS-1:0] sat_x;
    logic signed [COORD_BITS-1:0] sat_y;
    logic                      clip_x;
    logic                      clip_y;
    t_out_item                 n5_item;

    assign vx = TRUNC_W'(r4_tx >>> FRAC_BITS)
              + TRUNC_W'(r4_tx[SUM_W-1] && (r4_tx[FRAC_BITS-1:0] != '0));
    assign vy = TRUNC_W'(r4_ty >>> FRAC_BITS)
              + TRUNC_W'(r4_ty[SUM_W-1] && (r4_ty[FRAC_BITS-1:0] != '0));

    always_comb begin
        priority if (vx > C_MAX) begin
            sat_x  = C_MAX[COORD_BITS-1:0];
            clip_x = 1'b1;
        end else if (vx < C_MIN) begin
            sat_x  = C_MIN[COORD_BITS-1:0];
            clip_x = 1'b1;
        end else begin
            sat_x  = vx[COORD_BITS-1:0];
            clip_x = 1'b0;
        end
        priority if (vy > C_MAX) begin
            sat_y  = C_MAX[COORD_BITS-1:0];
            clip_y = 1'b1;
        end else if (vy < C_MIN) begin
            sat_y  = C_MIN[COORD_BITS-1:0];
            clip_y = 1'b1;
        end else begin
            sat_y  = vy[COORD_BITS-1:0];
            clip_y = 1'b0;
        end

        if (r4_side.near) begin
            n5_item.out_x       = r4_side.in_x;
            n5_item.out_y       = r4_side.in_y;
            n5_item.near_centre = 1'b1;
            n5_item.clipped     = 1'b0;
        end else begin
            n5_item.out_x       = sat_x;
            n5_item.out_y       = sat_y;
            n5_item.near_centre = 1'b0;
            n5_item.clipped     = clip_x | clip_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_item <= n5_item;
        end
    end

    // ---- output register; the pipe holds only when it has an item to hand on
    logic      r_out_valid;
    t_out_item r_out_item;

    assign last_valid  = r5_valid;
    assign adv         = !last_valid || !r_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out_item <= r5_item;
        end
    end

endmodule

// ----- sv/vsw_checker.sv -----
// Port-level checks for the swirl point warp, bound to the top level.
// Depends on vsw_pkg and vortex_swirl_point_warp_top.
module vsw_props import vsw_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // an empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with output empty");

    // pass-through points are never marked as saturated
    a_near_not_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.near_centre |-> !o_out_data.clipped)
        else $error("near point flagged clipped");

    // a saturated result sits on a bound
    a_clip_on_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clipped |->
            (o_out_data.out_x == C_MAX) || (o_out_data.out_x == C_MIN) ||
            (o_out_data.out_y == C_MAX) || (o_out_data.out_y == C_MIN))
        else $error("clipped result off the bounds");

endmodule

bind vortex_swirl_point_warp_top vsw_props u_vsw_props (.*);

// ----- dv/vsw_checker.sv -----
// Checker for the swirl point warp: keeps a copy of the registers, predicts each warped
// point as it is accepted and compares the results in order.
// Depends on vsw_pkg.
module vsw_checker import vsw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fails,
    output int                    o_pending
);

    localparam longint unsigned PI48     = 64'(PI_Q48);
    localparam longint unsigned TWO_PI48 = 64'(TWO_PI_Q48);

    logic signed [COORD_BITS-1:0] centre_x, centre_y;
    logic [TIME_W-1:0]            anim_time;
    logic signed [GAIN_W-1:0]     gain;
    t_out_item                    warped_q[$];
    int                           fails = 0;

    assign o_fails   = fails;
    assign o_pending = warped_q.size();

    function automatic longint fold_angle(bit neg, longint unsigned mag48);
        longint unsigned r;
        longint          q;
        r = mag48 % TWO_PI48;
        if (r > PI48) begin
            r = TWO_PI48 - r;
            neg = !neg;
        end
        q = longint'(r >> (48 - FRAC_BITS));
        return neg ? -q : q;
    endfunction

    function automatic void sin_cos(input longint th, output longint c, output longint s);
        longint pi_f, half_f, x, y, a, xs, ys;
        bit     flip;
        pi_f   = longint'(PI48 >> (48 - FRAC_BITS));
        half_f = longint'(PI48 >> (49 - FRAC_BITS));
        x      = longint'((64'(K_Q30) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        y      = 0;
        flip   = 0;
        if (th > half_f) begin
            th -= pi_f;
            flip = 1;
        end else if (th < -half_f) begin
            th += pi_f;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            a  = longint'((64'(ATAN_Q30[i]) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
            xs = x >>> i;
            ys = y >>> i;
            if (th >= 0) begin
                x -= ys;
                y += xs;
                th -= a;
            end else begin
                x += ys;
                y -= xs;
                th += a;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // floor(sqrt(d2 * 2^(2F))); the low pairs of the radicand are zero
    function automatic longint unsigned dist_qf(longint unsigned d2);
        longint unsigned root, rem, pair, trial;
        int pos;
        root = 0;
        rem  = 0;
        for (int k = COORD_BITS + FRAC_BITS; k >= 0; k--) begin
            pos   = k - FRAC_BITS;
            pair  = (pos >= 0) ? ((d2 >> (2 * pos)) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 64'd1;
            end else begin
                root <<= 1;
            end
        end
        return root;
    endfunction

    function automatic longint settle(longint centre, longint r, inout bit clip);
        longint v, hi, lo;
        v  = (centre * (64'sd1 <<< FRAC_BITS) + r) / (64'sd1 <<< FRAC_BITS);
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        lo = -(64'sd1 <<< (COORD_BITS - 1));
        if (v > hi) begin
            clip = 1;
            return hi;
        end
        if (v < lo) begin
            clip = 1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_out_item warp_point(t_in_item p);
        t_out_item       res;
        longint          dx, dy, tc, ts, ca, sa, g, ang;
        longint unsigned d2, dq, num, amag;
        bit              clip;
        clip = 0;
        dx   = longint'(p.in_x) - longint'(centre_x);
        dy   = longint'(p.in_y) - longint'(centre_y);
        d2   = longint'(dx * dx + dy * dy);
        if (d2 < 25) begin
            res.out_x       = p.in_x;
            res.out_y       = p.in_y;
            res.near_centre = 1'b1;
            res.clipped     = 1'b0;
            return res;
        end
        dq = dist_qf(d2);
        sin_cos(fold_angle(0, longint'(anim_time) << 31), tc, ts);
        g    = longint'(gain);
        num  = (64'd20 * (g < 0 ? -g : g) * (ts < 0 ? -ts : ts)) << (FRAC_BITS - 8);
        amag = num / dq;
        ang  = fold_angle((g < 0) != (ts < 0), amag << (48 - FRAC_BITS));
        sin_cos(ang, ca, sa);
        res.out_x       = COORD_BITS'(settle(centre_x, dx * ca - dy * sa, clip));
        res.out_y       = COORD_BITS'(settle(centre_y, dx * sa + dy * ca, clip));
        res.near_centre = 1'b0;
        res.clipped     = clip;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: MISMATCH %s", $realtime, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            centre_x  <= '0;
            centre_y  <= '0;
            anim_time <= '0;
            gain      <= GAIN_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X:   centre_x  <= i_cfg_data[COORD_BITS-1:0];
                    CFG_CENTER_Y:   centre_y  <= i_cfg_data[COORD_BITS-1:0];
                    CFG_FRAME_TIME: anim_time <= i_cfg_data[TIME_W-1:0];
                    CFG_SWIRL_GAIN: gain      <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                warped_q.push_back(warp_point(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (warped_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = warped_q.pop_front();
                    if (i_out_data.out_x !== want.out_x)
                        report_mismatch($sformatf("out_x %0d, want %0d",
                                                  i_out_data.out_x, want.out_x));
                    if (i_out_data.out_y !== want.out_y)
                        report_mismatch($sformatf("out_y %0d, want %0d",
                                                  i_out_data.out_y, want.out_y));
                    if (i_out_data.near_centre !== want.near_centre)
                        report_mismatch($sformatf("near_centre %b, want %b",
                                                  i_out_data.near_centre, want.near_centre));
                    if (i_out_data.clipped !== want.clipped)
                        report_mismatch($sformatf("clipped %b, want %b",
                                                  i_out_data.clipped, want.clipped));
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the swirl point warp: clock, reset, points and register writes under
// varying idle and stall patterns, and the verdict. Depends on vsw_pkg, vsw_checker and the block.
module tb_top;
    import vsw_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int LATENCY   = 129;
    localparam int CYCLE_CAP = 400000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_in_valid = 0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fails, pending;
    int                    idle_pct = 0, stall_pct = 0, cycles = 0;

    vortex_swirl_point_warp_top uut (.*);

    vsw_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        i_out_ready <= ($urandom_range(99) >= stall_pct);
        if (cycles > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_point(int x, int y);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= '{in_x: COORD_BITS'(x), in_y: COORD_BITS'(y)};
        do @(posedge i_clk); while (!o_in_ready);
        // drop valid only when a gap follows
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 8)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int cx, int cy, logic [31:0] t, int g);
        write_reg(CFG_CENTER_X, 32'(cx));
        write_reg(CFG_CENTER_Y, 32'(cy));
        write_reg(CFG_FRAME_TIME, t);
        write_reg(CFG_SWIRL_GAIN, 32'(g));
    endtask

    task automatic random_points(int n, int cx, int cy);
        int r, x, y;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 15) begin
                // close to the centre, across the near boundary
                x = cx + $urandom_range(12) - 6;
                y = cy + $urandom_range(12) - 6;
            end else if (r < 70) begin
                x = cx + $urandom_range(400) - 200;
                y = cy + $urandom_range(400) - 200;
            end else begin
                x = int'($urandom_range(65535)) - 32768;
                y = int'($urandom_range(65535)) - 32768;
            end
            send_point(x, y);
        end
    endtask

    initial begin
        int cx, cy;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, strong swirl at sin(1.5), a write to an unused index, corner centres
        send_point(0, 0);
        send_point(3, 4);
        send_point(4, 2);
        send_point(-4, -3);
        send_point(32767, 32767);
        send_point(-32768, -32768);
        send_point(-32768, 32767);
        send_point(100, -50);
        drain();
        set_all(0, 0, 32'h0003_0000, 32767);
        send_point(5, 0);
        send_point(0, -5);
        send_point(30000, 30000);
        send_point(-32768, 0);
        send_point(200, 100);
        drain();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_all(32767, -32768, 32'hFFFF_FFFF, -32768);
        send_point(-32768, 32767);
        send_point(32767, -32768);
        send_point(32765, -32766);
        send_point(32760, -32700);
        drain();
        set_all(-32768, 32767, 32'h0000_0000, 0);
        send_point(-32768, 32767);
        send_point(32767, -32768);
        send_point(-32000, 32000);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            cx = (ph == 6) ? 32767 : (ph == 7) ? -32768 : int'($urandom_range(4000)) - 2000;
            cy = (ph == 6) ? -32768 : int'($urandom_range(4000)) - 2000;
            set_all(cx, cy, $urandom(), int'($urandom_range(65535)) - 32768);
            random_points(128, cx, cy);
            drain();
        end

        if (fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
